FILE: hw/rtl/max_equal_cut_size_search_macros.svh
// assertion macros shared by the checker files
`ifndef MAX_EQUAL_CUT_SIZE_SEARCH_MACROS_SVH
`define MAX_EQUAL_CUT_SIZE_SEARCH_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MECS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mecs assertion failed");

// next-cycle implication, disabled while reset is low
`define MECS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mecs assertion failed");

`endif

FILE: hw/rtl/mecs_pkg.sv
// shared constants and types of the equal cut size search
package mecs_pkg;

  localparam int MaxBarsDef    = 1024;
  localparam int WeightBitsDef = 16;
  localparam int PeopleBits    = 16;
  localparam int BestBits      = 16;
  localparam logic [PeopleBits-1:0] PeopleReset = 16'd1;

  typedef enum logic [2:0] {
    StLoad,
    StMid,
    StRead,
    StDivStart,
    StDivWait,
    StDone
  } mecs_state_e;

endpackage

FILE: hw/rtl/mecs_divider.sv
// iterative restoring divider, one quotient bit per cycle
module mecs_divider #(
  parameter int WEIGHT_BITS = mecs_pkg::WeightBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [WEIGHT_BITS-1:0] dividend_i,
  input  logic [WEIGHT_BITS-1:0] divisor_i,
  output logic                   done_o,
  output logic [WEIGHT_BITS-1:0] quotient_o
);
  import mecs_pkg::*;

  localparam int CntW = $clog2(WEIGHT_BITS);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [WEIGHT_BITS-1:0] dvd_q, dvd_d;
  logic [WEIGHT_BITS-1:0] dvs_q, dvs_d;
  logic [WEIGHT_BITS-1:0] rem_q, rem_d;
  logic [WEIGHT_BITS-1:0] quo_q, quo_d;
  logic [WEIGHT_BITS:0]   rem_sh;
  logic [WEIGHT_BITS:0]   rem_sub;
  logic                   fits;

  // one trial subtraction per cycle
  always_comb begin
    rem_sh  = {rem_q, dvd_q[WEIGHT_BITS-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};
  end

  // sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WEIGHT_BITS - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[WEIGHT_BITS-2:0], 1'b0};
      rem_d = fits ? rem_sub[WEIGHT_BITS-1:0] : rem_sh[WEIGHT_BITS-1:0];
      quo_d = {quo_q[WEIGHT_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/max_equal_cut_size_search.sv
// equal cut size search: bar store, binary search sequencer and output register
//
// channel   dir  signals                      fields (low bit up)
// s_*       in   tvalid tready tdata tlast    tdata: bar_weight; tlast: last_bar
// m_*       out  tvalid tready tdata          tdata: best_size
// cfg_*     in   we wdata                     wdata: people_count
//
// a bar beat that is not last keeps the block loading; s_tready_o stays high between them.
// a last beat starts the search: about (WEIGHT_BITS + 1) probes, each reading the
// stored bars in turn and dividing each by the probe size in the shared divider.
// a probe stops early once the piece count is reached.
// reset empties the bar set and sets people_count to one; the store needs no clearing.
// the result sits in an output register, so bar loading resumes while it waits.
module max_equal_cut_size_search #(
  parameter int MAX_BARS    = mecs_pkg::MaxBarsDef,
  parameter int WEIGHT_BITS = mecs_pkg::WeightBitsDef,
  localparam int InDataW    = ((WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // bar_weight [WEIGHT_BITS-1:0]
  input  logic [InDataW-1:0]             s_tdata_i,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic                           s_tlast_i,
  // best_size [15:0]
  output logic [mecs_pkg::BestBits-1:0]  m_tdata_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // people_count [15:0]
  input  logic                           cfg_we_i,
  input  logic [mecs_pkg::PeopleBits-1:0] cfg_wdata_i
);
  import mecs_pkg::*;

  localparam int CntW = $clog2(MAX_BARS + 1);
  localparam int AdrW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int SumW = ((WEIGHT_BITS > PeopleBits) ? WEIGHT_BITS : PeopleBits) + 1;
  localparam int WB   = WEIGHT_BITS;

  mecs_state_e state_q, state_d;

  logic [PeopleBits-1:0] people_q, people_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [WB-1:0]         largest_q, largest_d;
  logic [WB:0]           low_q, low_d;
  logic [WB:0]           high_q, high_d;
  logic [WB-1:0]         mid_q, mid_d;
  logic [WB-1:0]         best_q, best_d;
  logic [PeopleBits-1:0] psum_q, psum_d;
  logic [AdrW-1:0]       idx_q, idx_d;
  logic                  ovalid_q, ovalid_d;
  logic [BestBits-1:0]   odata_q, odata_d;

  logic [WB-1:0] mem_q [MAX_BARS];
  logic [WB-1:0] rdata_q;

  logic          in_beat;
  logic          store_ok;
  logic [WB-1:0] weight;
  logic [WB-1:0] largest_new;
  logic [WB:0]   mid_sum;
  logic [SumW-1:0] sum_new;
  logic          probe_pass;
  logic          last_bar_idx;
  logic          div_start;
  logic          div_done;
  logic [WB-1:0] div_quo;

  // input beat decode and running maximum
  always_comb begin
    weight       = s_tdata_i[WB-1:0];
    in_beat      = s_tvalid_i && s_tready_o;
    store_ok     = count_q < CntW'(MAX_BARS);
    largest_new  = (store_ok && (weight > largest_q)) ? weight : largest_q;
    mid_sum      = low_q + high_q;
    sum_new      = SumW'(psum_q) + SumW'(div_quo);
    probe_pass   = sum_new >= SumW'(people_q);
    last_bar_idx = (CntW'(idx_q) + 1'b1) == count_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_beat && s_tlast_i) state_d = StMid;
      end
      StMid: begin
        if (low_q > high_q) begin
          state_d = StDone;
        end else if (mid_sum[WB:1] != '0) begin
          state_d = StRead;
        end
      end
      StRead:     state_d = StDivStart;
      StDivStart: state_d = StDivWait;
      StDivWait: begin
        if (div_done) begin
          state_d = (probe_pass || last_bar_idx) ? StMid : StRead;
        end
      end
      StDone: begin
        if (!ovalid_q || m_tready_i) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  // datapath and outputs
  always_comb begin
    people_d  = cfg_we_i ? cfg_wdata_i : people_q;
    count_d   = count_q;
    largest_d = largest_q;
    low_d     = low_q;
    high_d    = high_q;
    mid_d     = mid_q;
    best_d    = best_q;
    psum_d    = psum_q;
    idx_d     = idx_q;
    odata_d   = odata_q;
    ovalid_d  = (ovalid_q && m_tready_i) ? 1'b0 : ovalid_q;
    div_start = 1'b0;
    s_tready_o = 1'b0;
    case (state_q)
      StLoad: begin
        s_tready_o = 1'b1;
        if (in_beat) begin
          largest_d = largest_new;
          if (store_ok) count_d = count_q + 1'b1;
          if (s_tlast_i) begin
            low_d  = '0;
            high_d = (WB+1)'(largest_new);
            best_d = '0;
          end
        end
      end
      StMid: begin
        if (low_q <= high_q) begin
          mid_d = mid_sum[WB:1];
          if (mid_sum[WB:1] == '0) begin
            // size zero always passes
            best_d = '0;
            low_d  = (WB+1)'(1);
          end else begin
            psum_d = '0;
            idx_d  = '0;
          end
        end
      end
      StDivStart: begin
        div_start = 1'b1;
      end
      StDivWait: begin
        if (div_done) begin
          psum_d = probe_pass ? people_q : sum_new[PeopleBits-1:0];
          idx_d  = idx_q + 1'b1;
          if (probe_pass) begin
            best_d = mid_q;
            low_d  = (WB+1)'(mid_q) + 1'b1;
          end else if (last_bar_idx) begin
            high_d = (WB+1)'(mid_q) - 1'b1;
          end
        end
      end
      StDone: begin
        if (!ovalid_q || m_tready_i) begin
          odata_d   = BestBits'(best_q);
          ovalid_d  = 1'b1;
          count_d   = '0;
          largest_d = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      people_q  <= PeopleReset;
      count_q   <= '0;
      largest_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      people_q  <= people_d;
      count_q   <= count_d;
      largest_q <= largest_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // search working registers
  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    high_q  <= high_d;
    mid_q   <= mid_d;
    best_q  <= best_d;
    psum_q  <= psum_d;
    idx_q   <= idx_d;
    odata_q <= odata_d;
  end

  // bar store: write on a loaded beat, registered read during the search
  always_ff @(posedge clk_i) begin
    if (in_beat && store_ok) mem_q[count_q[AdrW-1:0]] <= weight;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRead) rdata_q <= mem_q[idx_q];
  end

  // shared divider: stored weight over probe size
  mecs_divider #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rdata_q),
    .divisor_i  (mid_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_tdata_o  = odata_q;
  assign m_tvalid_o = ovalid_q;

endmodule

FILE: hw/rtl/mecs_checker.sv
// port-level checks of the equal cut size search, bound to the top level
`include "max_equal_cut_size_search_macros.svh"

module mecs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_tvalid_i,
  input logic s_tready_o,
  input logic s_tlast_i,
  input logic m_tvalid_o,
  input logic m_tready_i
);
  import mecs_pkg::*;

  logic mid_beat;
  logic end_beat;

  // beat classes on the input side
  assign mid_beat = s_tvalid_i && s_tready_o && !s_tlast_i;
  assign end_beat = s_tvalid_i && s_tready_o && s_tlast_i;

  // a stalled result stays offered
  `MECS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o)

  // plain bars stream without a gap
  `MECS_ASSERT_NXT(a_load_streams, clk_i, rst_ni, mid_beat, s_tready_o)

  // a last bar closes the input while the search runs
  `MECS_ASSERT_NXT(a_search_busy, clk_i, rst_ni, end_beat, !s_tready_o)

  // a new result shows up just as loading reopens
  `MECS_ASSERT_IMP(a_result_reopens, clk_i, rst_ni, $rose(m_tvalid_o),
                   s_tready_o && !$past(s_tready_o))

endmodule

bind max_equal_cut_size_search mecs_checker u_mecs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tlast_i  (s_tlast_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i)
);
